// ===== sv/vac_pkg.sv =====
// ----------------------------------------------------------------------------
// vac_pkg: shared types and helpers for the alphanumeric Vigenere cipher
// Payload structs, register indexes and the alphabet mapping functions.
// ----------------------------------------------------------------------------
package vac_pkg;

    localparam int KEY_MAX      = 16;
    localparam int POS_W        = $clog2(KEY_MAX);
    localparam int LEN_W        = 5;
    localparam int ALPHA_SIZE   = 36;
    localparam int IDX_W        = 6;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS_HIGH = 8'd3;

    localparam logic [63:0] KEY_CHARS_RESET = 64'h4141_4141_4141_4141;

    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] DIGIT_OFFSET  = 8'd22;  // '0' (48) lands on index 26

    typedef struct packed {
        logic [7:0] symbol_in;
        logic       first;
    } vac_in_t;

    typedef struct packed {
        logic [7:0] symbol_out;
        logic       bad_char;
    } vac_out_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } vac_idx_t;

    // ASCII to alphabet index; ok low for anything outside A-Z / 0-9
    function automatic vac_idx_t char_to_index(input logic [7:0] ch);
        vac_idx_t   res;
        logic [7:0] diff;
        res  = '0;
        diff = '0;
        if (ch inside {[8'd65:8'd90]}) begin
            diff    = ch - ASCII_UPPER_A;
            res.ok  = 1'b1;
            res.idx = diff[IDX_W-1:0];
        end else if (ch inside {[8'd48:8'd57]}) begin
            diff    = ch - DIGIT_OFFSET;
            res.ok  = 1'b1;
            res.idx = diff[IDX_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] index_to_char(input logic [IDX_W-1:0] idx);
        logic [7:0] wide;
        wide = {{(8-IDX_W){1'b0}}, idx};
        return (idx < IDX_W'(26)) ? wide + ASCII_UPPER_A : wide + DIGIT_OFFSET;
    endfunction

endpackage

// ===== sv/vigenere_alnum_cipher.sv =====
// ----------------------------------------------------------------------------
// vigenere_alnum_cipher: Vigenere cipher over A-Z then 0-9
// Streams one ASCII character per transfer, adds or subtracts the key
// character index mod 36, and flags characters outside the alphabet.
// ----------------------------------------------------------------------------
//  channel   ports                          payload
//  input     s_valid / s_ready / s_data     vac_in_t  {symbol_in, first}
//  result    m_valid / m_ready / m_data     vac_out_t {symbol_out, bad_char}
//  config    cfg_valid / cfg_ready          cfg_index (8b), cfg_data (64b)
//
//  One character per cycle sustained while m_ready holds the result channel open; an input
//  transfer reaches result valid through the input register, then the result register.
//  The key position advances at the input transfer, so it is the only
//  loop and it closes through the key position register alone.
//  aresetn (synchronous, active low) clears valids, key position and
//  restores the register defaults. A stalled result holds both stages;
//  s_ready stays high while the input stage can move forward.
// ----------------------------------------------------------------------------
module vigenere_alnum_cipher
    import vac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vac_in_t               s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output vac_out_t              m_data,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic             direction_reg;
    logic [LEN_W-1:0] key_length_reg;
    logic [63:0]      key_chars_low_reg;
    logic [63:0]      key_chars_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg      <= 1'b0;
            key_length_reg     <= LEN_W'(1);
            key_chars_low_reg  <= KEY_CHARS_RESET;
            key_chars_high_reg <= KEY_CHARS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DIRECTION:      direction_reg      <= cfg_data[0];
                CFG_KEY_LENGTH:     key_length_reg     <= cfg_data[LEN_W-1:0];
                CFG_KEY_CHARS_LOW:  key_chars_low_reg  <= cfg_data;
                CFG_KEY_CHARS_HIGH: key_chars_high_reg <= cfg_data;
                default: ;          // unknown index: ignored
            endcase
        end
    end

    // effective key length: zero reads as one, saturate at KEY_MAX
    logic [LEN_W-1:0] eff_len;
    always_comb begin
        if (key_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (key_length_reg > LEN_W'(KEY_MAX))
            eff_len = LEN_W'(KEY_MAX);
        else
            eff_len = key_length_reg;
    end

    // ------------------------------------------------------------------
    // handshake: two-stage pipeline, each stage moves when the next frees
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_advance;
    logic s_xfer;

    assign s1_advance = !m_valid || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_xfer     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // key position: pick the position for this character at transfer time
    // ------------------------------------------------------------------
    logic [POS_W-1:0] key_pos_reg;
    logic [POS_W-1:0] key_pos_next;
    logic [POS_W-1:0] pos_raw;
    logic [POS_W-1:0] pos_use;
    logic [LEN_W-1:0] pos_inc;

    always_comb begin
        pos_raw = s_data.first ? '0 : key_pos_reg;
        // position left past a shortened key falls back to zero
        pos_use = ({{(LEN_W-POS_W){1'b0}}, pos_raw} >= eff_len) ? '0 : pos_raw;
        pos_inc = {{(LEN_W-POS_W){1'b0}}, pos_use} + LEN_W'(1);
        key_pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            key_pos_reg <= '0;
        else if (s_xfer)
            key_pos_reg <= key_pos_next;
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic [7:0]       s1_symbol_reg;
    logic [POS_W-1:0] s1_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s1_valid_reg <= 1'b0;
        else if (s_ready)
            s1_valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_symbol_reg <= s_data.symbol_in;
            s1_pos_reg    <= pos_use;
        end
    end

    // ------------------------------------------------------------------
    // stage 2 logic: key lookup, mapping, mod-36 add or subtract
    // ------------------------------------------------------------------
    logic [63:0]  key_word;
    logic [7:0]   key_char;
    vac_idx_t     p_map;
    vac_idx_t     k_map;
    logic [6:0]   sum;
    logic [6:0]   sum_mod;
    vac_out_t     result;

    always_comb begin
        key_word = s1_pos_reg[POS_W-1] ? key_chars_high_reg : key_chars_low_reg;
        key_char = key_word[{s1_pos_reg[POS_W-2:0], 3'b000} +: 8];
        p_map    = char_to_index(s1_symbol_reg);
        k_map    = char_to_index(key_char);

        // decrypt adds 36 first so the difference stays non-negative
        if (direction_reg)
            sum = {1'b0, p_map.idx} + 7'(ALPHA_SIZE) - {1'b0, k_map.idx};
        else
            sum = {1'b0, p_map.idx} + {1'b0, k_map.idx};
        // sum < 72, one conditional subtract finishes the modulo
        sum_mod = (sum >= 7'(ALPHA_SIZE)) ? sum - 7'(ALPHA_SIZE) : sum;

        if (p_map.ok && k_map.ok) begin
            result.symbol_out = index_to_char(sum_mod[IDX_W-1:0]);
            result.bad_char   = 1'b0;
        end else begin
            result.symbol_out = 8'd0;
            result.bad_char   = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid <= 1'b0;
        else if (s1_advance)
            m_valid <= s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg)
            m_data <= result;
    end

endmodule

// ===== test/vigenere_alnum_cipher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vigenere_alnum_cipher_tb: self-checking bench for the alphanumeric Vigenere
// Streams characters through the cipher under changing key, length and
// direction settings, predicts every result in the bench and compares field
// by field, with random sender gaps, receiver stalls and long hold-offs.
// ----------------------------------------------------------------------------
module vigenere_alnum_cipher_tb;
    import vac_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 6;     // pipeline is two deep, keep margin
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int SEGMENTS       = 16;
    localparam int SEGMENT_CHARS  = 118;
    localparam int MAX_PRINTS     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_KEY_CHARS_HIGH + 8'd1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mix_t;

    // ------------------------------------------------------------------
    // DUT ports, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    vac_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    vac_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    vigenere_alnum_cipher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    vac_in_t  pending_chars[$];    // characters waiting for the driver
    vac_out_t expected_chars[$];   // predicted results, oldest first

    // mirror of the cipher's registers and key pointer
    logic        dir_q     = 1'b0;
    logic [4:0]  klen_q    = 5'd1;
    logic [63:0] key_lo_q  = KEY_CHARS_RESET;
    logic [63:0] key_hi_q  = KEY_CHARS_RESET;
    logic [3:0]  key_pos_q = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;         // bumped by the sequencer to start a hold-off
    int hold_ack      = 0;
    int hold_left     = 0;
    bit in_fire       = 1'b0;      // input transfer at the last rising edge
    int quiet_cycles  = 0;

    int fail_count  = 0;
    int chars_in    = 0;
    int results_in  = 0;
    int bad_results = 0;
    int reg_writes  = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // A-Z -> 0..25, 0-9 -> 26..35; returns 0 for anything else
    function automatic bit alnum_index(input logic [7:0] ch, output int idx);
        idx = 0;
        if (ch >= "A" && ch <= "Z") begin
            idx = int'(ch) - int'(ASCII_UPPER_A);
            return 1'b1;
        end
        if (ch >= "0" && ch <= "9") begin
            idx = int'(ch) - int'(DIGIT_OFFSET);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Result of one character under the mirrored settings; moves the key pointer.
    function automatic vac_out_t cipher_step(input vac_in_t item);
        vac_out_t    res;
        int          span, pos, p_idx, k_idx, sum;
        bit          p_ok, k_ok;
        logic [7:0]  key_byte;
        span = (klen_q == 0) ? 1 : ((klen_q > KEY_MAX) ? KEY_MAX : int'(klen_q));
        pos  = item.first ? 0 : int'(key_pos_q);
        // pointer left beyond a shortened key falls back to the start
        if (pos >= span)
            pos = 0;
        key_byte = (pos < 8) ? key_lo_q[pos*8 +: 8] : key_hi_q[(pos-8)*8 +: 8];
        p_ok = alnum_index(item.symbol_in, p_idx);
        k_ok = alnum_index(key_byte, k_idx);
        res  = '0;
        if (p_ok && k_ok) begin
            if (dir_q)
                sum = (p_idx + ALPHA_SIZE - k_idx) % ALPHA_SIZE;
            else
                sum = (p_idx + k_idx) % ALPHA_SIZE;
            res.symbol_out = (sum < 26) ? 8'(sum + int'(ASCII_UPPER_A))
                                        : 8'(sum + int'(DIGIT_OFFSET));
        end else begin
            // bad text or key character: zero out, but the pointer still moves
            res.bad_char = 1'b1;
        end
        pos = pos + 1;
        if (pos >= span)
            pos = 0;
        key_pos_q = 4'(pos);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] result %0d: %s expected %0h got %0h",
                     $realtime, results_in, what, want, got);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        vac_out_t want;
        in_fire <= s_valid && s_ready;
        if (aresetn) begin
            // register transfer: only ever issued while the cipher is idle
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIRECTION:      dir_q    = cfg_data[0];
                    CFG_KEY_LENGTH:     klen_q   = cfg_data[4:0];
                    CFG_KEY_CHARS_LOW:  key_lo_q = cfg_data;
                    CFG_KEY_CHARS_HIGH: key_hi_q = cfg_data;
                    default: ;  // unknown index, no effect
                endcase
                reg_writes++;
            end
            if (s_valid && s_ready) begin
                expected_chars.push_back(cipher_step(s_data));
                chars_in++;
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected result, symbol_out", 0,
                                    int'(m_data.symbol_out));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.symbol_out !== want.symbol_out)
                        report_mismatch("symbol_out", int'(want.symbol_out),
                                        int'(m_data.symbol_out));
                    if (m_data.bad_char !== want.bad_char)
                        report_mismatch("bad_char", int'(want.bad_char),
                                        int'(m_data.bad_char));
                end
                if (m_data.bad_char === 1'b1)
                    bad_results++;
                results_in++;
            end
        end
    end

    // Watchdog: no transfer of any kind for too long means a hang
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_chars.size());
            $display("vigenere_alnum_cipher_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: input channel, changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            // slot is free: offer the next character unless idling this cycle
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_chars.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a counted hold-off when requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] sym, input logic first);
        vac_in_t item;
        item.symbol_in = sym;
        item.first     = first;
        pending_chars.push_back(item);
    endtask

    // register transfer; caller makes sure the cipher is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // everything queued has gone in and every result has come back
    task automatic wait_idle();
        while (pending_chars.size() != 0 || s_valid || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_alnum();
        int idx;
        idx = $urandom_range(ALPHA_SIZE - 1);
        return (idx < 26) ? 8'(idx + int'(ASCII_UPPER_A)) : 8'(idx + int'(DIGIT_OFFSET));
    endfunction

    // eight key characters, a few of them possibly outside the alphabet
    function automatic logic [63:0] random_key_word(input int bad_pct);
        logic [63:0] word;
        for (int i = 0; i < 8; i++)
            word[i*8 +: 8] = ($urandom_range(99) < bad_pct) ? 8'($urandom_range(255))
                                                             : rand_alnum();
        return word;
    endfunction

    task automatic set_idle_mix(input idle_mix_t mix);
        case (mix)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 72; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 72; end
            default:       begin send_idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    // One random phase: fresh settings, then mostly well-formed messages
    // with some stray bytes mixed in. force_len < 0 picks a length at random.
    task automatic run_segment(input int seg, input int force_len, input bit press);
        logic [63:0] dir_word, len_word;
        int          sel, queued, msg_len, bad_pct;
        dir_word    = {$urandom, $urandom};
        dir_word[0] = 1'(seg % 2);
        sel = $urandom_range(19);
        if (force_len >= 0)
            len_word = 64'(force_len);
        else if (sel == 0)
            len_word = '0;                              // zero length acts as one
        else if (sel == 1)
            len_word = 64'($urandom_range(31, 17));     // saturates at sixteen
        else if (sel == 2)
            len_word = {$urandom, $urandom};            // junk above the field
        else
            len_word = 64'($urandom_range(KEY_MAX, 1));
        bad_pct = (seg % 3 == 0) ? 8 : 0;
        write_reg(CFG_DIRECTION, dir_word);
        write_reg(CFG_KEY_LENGTH, len_word);
        write_reg(CFG_KEY_CHARS_LOW, random_key_word(bad_pct));
        write_reg(CFG_KEY_CHARS_HIGH, random_key_word(bad_pct));
        write_reg(8'($urandom_range(255, CFG_FIRST_UNUSED)), {$urandom, $urandom});
        set_idle_mix(idle_mix_t'(seg % 4));

        queued = 0;
        while (queued < SEGMENT_CHARS) begin
            if ($urandom_range(99) < 12) begin
                queue_char(8'($urandom_range(255)), 1'($urandom_range(1)));
                queued++;
            end else begin
                msg_len = $urandom_range(24, 1);
                for (int i = 0; i < msg_len && queued < SEGMENT_CHARS; i++) begin
                    queue_char(($urandom_range(99) < 4) ? 8'($urandom_range(255))
                                                        : rand_alnum(), i == 0);
                    queued++;
                end
            end
        end
        // receiver goes quiet while the sender keeps offering: the pipe
        // fills and s_ready has to drop
        if (press)
            hold_req++;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset key is all 'A', length one, encrypt: alphabet edges pass
        // through unchanged, anything outside the alphabet is flagged
        queue_char("A", 1'b1);
        queue_char("Z", 1'b0);
        queue_char("0", 1'b0);
        queue_char("9", 1'b1);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b1);
        queue_char("@", 1'b0);
        queue_char("[", 1'b0);
        queue_char("/", 1'b0);
        queue_char(":", 1'b0);
        wait_idle();

        // decrypt with a full sixteen-character key; the set bits above the
        // fields must be dropped, and key character 12 is lower-case 'a'
        write_reg(CFG_DIRECTION, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_LENGTH, 64'h0000_0000_0000_00F0);
        write_reg(CFG_KEY_CHARS_LOW, 64'h3151_4B35_4130_5A39);   // "9Z0A5KQ1"
        write_reg(CFG_KEY_CHARS_HIGH, 64'h4432_5961_3742_384D);  // "M8B7aY2D"
        queue_char("A", 1'b1);
        queue_char("9", 1'b0);
        queue_char("Z", 1'b0);
        queue_char("0", 1'b0);
        for (int i = 0; i < 10; i++)
            queue_char(rand_alnum(), 1'b0);
        wait_idle();

        // key pointer now sits at 14; shortening the key leaves it beyond
        // the end, so the next character starts over at position zero
        write_reg(CFG_KEY_LENGTH, 64'd3);
        queue_char("M", 1'b0);
        wait_idle();

        // writes to indexes past the register list do nothing
        write_reg(CFG_FIRST_UNUSED, 64'hDEAD_BEEF_0123_4567);
        write_reg(8'hFF, '1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       run_segment(seg, 1, 1'b0);
                1:       run_segment(seg, KEY_MAX, 1'b0);
                2:       run_segment(seg, 0, 1'b0);
                3:       run_segment(seg, 31, 1'b0);
                4, 9:    run_segment(seg, -1, 1'b1);
                default: run_segment(seg, -1, 1'b0);
            endcase
        end
        wait_idle();

        $display("Ran %0d characters through the cipher, %0d results checked (%0d flagged bad)",
                 chars_in, results_in, bad_results);
        $display("%0d register transfers across %0d settings, all idle mixes, two long hold-offs",
                 reg_writes, SEGMENTS + 3);
        if (fail_count == 0) begin
            $display("vigenere_alnum_cipher_tb: PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("vigenere_alnum_cipher_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/vac_pkg.sv
sv/vigenere_alnum_cipher.sv
test/vigenere_alnum_cipher_tb.sv
